[hw/rtl/bta_pkg.sv]
// ----------------------------------------------------------------------------
// bta_pkg
// Shared constants and types of the batch timeslot allocator.
// ----------------------------------------------------------------------------
package bta_pkg;

	// Field widths of the stream items and the register.
	localparam int NODE_W    = 6;
	localparam int SLOT_W    = 3;
	localparam int COUNT_W   = 32;
	localparam int ALLOWED_W = 8;

	// Width of the internal slot index, enough for the largest slot count.
	localparam int SIDX_W = 6;

	// Default sizes.
	localparam int NODES_DEF = 64;
	localparam int SLOTS_DEF = 8;

	localparam logic [ALLOWED_W-1:0] ALLOWED_RST = 8'hFF;
	localparam logic [COUNT_W-1:0]   COUNT_MAX   = 32'hFFFF_FFFF;

	typedef enum logic {
		OP_DEMAND    = 1'b0,
		OP_NEW_BATCH = 1'b1
	} op_t;

endpackage

[hw/rtl/bta_ram.sv]
// ----------------------------------------------------------------------------
// bta_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hw/rtl/bta_free_map.sv]
// ----------------------------------------------------------------------------
// bta_free_map
// Free-slot bitmaps of one side (sources or destinations): RAM storage,
// per-entry valid bits for the all-free state and a write bypass.
// ----------------------------------------------------------------------------
module bta_free_map #(
	parameter int NODES = bta_pkg::NODES_DEF,
	parameter int SLOTS = bta_pkg::SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(NODES)-1:0] rd_addr,
	input  logic [$clog2(NODES)-1:0] lk_addr,
	output logic [SLOTS-1:0]         free_bits,
	input  logic                     wr_en,
	input  logic [SLOTS-1:0]         wr_data,
	input  logic                     clr
);

	localparam int AW = $clog2(NODES);

	logic [SLOTS-1:0] ram_rdata;
	logic [NODES-1:0] vld_q;
	logic             fwd_vld_q;
	logic [AW-1:0]    fwd_addr_q;
	logic [SLOTS-1:0] fwd_data_q;

	bta_ram #(
		.WIDTH(SLOTS),
		.DEPTH(NODES)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(lk_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// The bypass covers a write that landed in the same cycle as the read.
	// An entry without its valid bit has been free since the last new batch.
	always_comb begin
		priority if (fwd_vld_q && (fwd_addr_q == lk_addr)) begin
			free_bits = fwd_data_q;
		end else if (!vld_q[lk_addr]) begin
			free_bits = '1;
		end else begin
			free_bits = ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			fwd_vld_q <= 1'b0;
		end else if (clr) begin
			vld_q     <= '0;
			fwd_vld_q <= 1'b0;
		end else if (wr_en) begin
			vld_q[lk_addr] <= 1'b1;
			fwd_vld_q      <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= lk_addr;
			fwd_data_q <= wr_data;
		end
	end

endmodule

[hw/rtl/batch_timeslot_allocator_top.sv]
// ----------------------------------------------------------------------------
// batch_timeslot_allocator_top
// Greedy timeslot allocator: grants the lowest allowed slot free at both endpoints.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on the s_ stream. s_tuser is the operation: a demand
//   for one slot between a source and a destination node, or a new batch
//   that frees every slot of every node. Each input word gives exactly one
//   output word on the m_ stream: the grant flag in m_tuser, the slot and
//   the running grant count in m_tdata.
//   The bitmaps are read from RAM at the edge that accepts a word; the
//   lookup stage combines them with the allowed-slot mask, picks the lowest
//   common free slot and, once the output register is free, writes back while
//   the result register loads in the same cycle.
//   One word is accepted every cycle while the output is taken.
//   When the receiver stalls, the held result and one word in the lookup
//   stage wait; s_tready drops until the output register frees up.
//   Reset frees all slots, clears the grant count and opens every slot in
//   the allowed mask. cfg_we writes the mask; write it only while idle.
// ----------------------------------------------------------------------------
module batch_timeslot_allocator_top #(
	parameter int NODES = bta_pkg::NODES_DEF,
	parameter int SLOTS = bta_pkg::SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // source_node[5:0], dest_node[11:6], zeros
	input  logic [0:0]  s_tuser,   // op[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // slot[2:0], grant_count[34:3], zeros
	output logic [0:0]  m_tuser    // granted[0]
);

	localparam int AW      = $clog2(NODES);
	localparam int NODE_W  = bta_pkg::NODE_W;
	localparam int SIDX_W  = bta_pkg::SIDX_W;
	localparam int COUNT_W = bta_pkg::COUNT_W;
	localparam int SLOT_W  = bta_pkg::SLOT_W;

	logic [bta_pkg::ALLOWED_W-1:0] allowed_q;

	logic [AW-1:0] wrap_tbl [2**NODE_W];
	logic [AW-1:0] in_src;
	logic [AW-1:0] in_dst;
	logic          accept;
	logic          advance;

	logic           s1_valid;
	bta_pkg::op_t   s1_op;
	logic [AW-1:0]  s1_src;
	logic [AW-1:0]  s1_dst;

	logic [SLOTS-1:0] src_free;
	logic [SLOTS-1:0] dst_free;
	logic [SLOTS-1:0] common;
	logic [SLOTS-1:0] low_bit;
	logic [SIDX_W-1:0] pick_idx;
	logic             hit;
	logic             wr_en;
	logic             clr;

	logic [COUNT_W-1:0] total_q;
	logic [COUNT_W-1:0] total_next;

	logic               m_granted_q;
	logic [SLOT_W-1:0]  m_slot_q;
	logic [COUNT_W-1:0] m_count_q;

	// Node indices wrap modulo NODES; the table is fixed at elaboration.
	for (genvar i = 0; i < 2**NODE_W; i++) begin : g_wrap
		assign wrap_tbl[i] = AW'(i % NODES);
	end

	assign in_src = wrap_tbl[s_tdata[NODE_W-1:0]];
	assign in_dst = wrap_tbl[s_tdata[2*NODE_W-1:NODE_W]];

	assign advance  = s1_valid && (!m_tvalid || m_tready);
	assign s_tready = !s1_valid || advance;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allowed_q <= bta_pkg::ALLOWED_RST;
		end else if (cfg_we) begin
			allowed_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (advance) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_op  <= bta_pkg::op_t'(s_tuser[0]);
			s1_src <= in_src;
			s1_dst <= in_dst;
		end
	end

	bta_free_map #(
		.NODES(NODES),
		.SLOTS(SLOTS)
	) u_src_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (in_src),
		.lk_addr  (s1_src),
		.free_bits(src_free),
		.wr_en    (wr_en),
		.wr_data  (src_free & ~low_bit),
		.clr      (clr)
	);

	bta_free_map #(
		.NODES(NODES),
		.SLOTS(SLOTS)
	) u_dst_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_addr  (in_dst),
		.lk_addr  (s1_dst),
		.free_bits(dst_free),
		.wr_en    (wr_en),
		.wr_data  (dst_free & ~low_bit),
		.clr      (clr)
	);

	// Mask bits above SLOTS are dropped; missing ones read as not allowed.
	assign common  = SLOTS'(allowed_q) & src_free & dst_free;
	assign low_bit = common & (~common + SLOTS'(1));
	assign hit     = (s1_op == bta_pkg::OP_DEMAND) && (|common);
	assign wr_en   = advance && hit;
	assign clr     = advance && (s1_op == bta_pkg::OP_NEW_BATCH);

	always_comb begin
		pick_idx = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (low_bit[i]) begin
				pick_idx = pick_idx | SIDX_W'(i);
			end
		end
	end

	assign total_next = (hit && (total_q != bta_pkg::COUNT_MAX)) ? total_q + COUNT_W'(1)
		: total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			m_tvalid <= 1'b0;
		end else if (advance) begin
			total_q  <= total_next;
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_granted_q <= hit;
			m_slot_q    <= hit ? pick_idx[SLOT_W-1:0] : '0;
			m_count_q   <= total_next;
		end
	end

	assign m_tuser = m_granted_q;
	assign m_tdata = {5'b0, m_count_q, m_slot_q};

endmodule
